// ===== design/assert_macros.svh =====
// Assertion macros shared by the filter RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== design/kf2d_pkg.sv =====
// Shared types, constants and saturation helpers of the 2-D Kalman step.
// No dependencies.
package kf2d_pkg;

    typedef logic signed [31:0] t_q16;
    typedef logic signed [51:0] t_wide;

    localparam int unsigned QuoW = 48;

    // configuration register indexes
    localparam logic [2:0] REG_WALL_X  = 3'd0;
    localparam logic [2:0] REG_WALL_Y  = 3'd1;
    localparam logic [2:0] REG_PN_XX   = 3'd2;
    localparam logic [2:0] REG_PN_XY   = 3'd3;
    localparam logic [2:0] REG_PN_YY   = 3'd4;
    localparam logic [2:0] REG_MN_XX   = 3'd5;
    localparam logic [2:0] REG_MN_XY   = 3'd6;
    localparam logic [2:0] REG_MN_YY   = 3'd7;

    localparam t_q16 RST_WALL_X = 32'sd1310720;
    localparam t_q16 RST_WALL_Y = 32'sd655360;
    localparam t_q16 RST_PN_XX  = 32'sd19661;
    localparam t_q16 RST_PN_YY  = 32'sd26214;
    localparam t_q16 RST_MN_XX  = 32'sd26214;
    localparam t_q16 RST_MN_YY  = 32'sd26214;
    localparam t_q16 RST_MEAN_X = 32'sd720896;
    localparam t_q16 RST_MEAN_Y = 32'sd229376;
    localparam t_q16 RST_COV0   = 32'sd26214;
    localparam t_q16 RST_COV1   = 32'sd6554;
    localparam t_q16 RST_COV2   = 32'sd6554;
    localparam t_q16 RST_COV3   = 32'sd32768;

    localparam t_q16 Q16_MAX = 32'sh7FFF_FFFF;
    localparam t_q16 Q16_MIN = 32'sh8000_0000;

    function automatic t_wide f_ext(input t_q16 a);
        f_ext = t_wide'(a);
    endfunction

    // clamp a wide value into the signed 32-bit range
    function automatic t_q16 f_sat32(input t_wide v);
        if (v > f_ext(Q16_MAX)) begin
            f_sat32 = Q16_MAX;
        end else if (v < f_ext(Q16_MIN)) begin
            f_sat32 = Q16_MIN;
        end else begin
            f_sat32 = v[31:0];
        end
    endfunction

endpackage

// ===== design/kf2d_div.sv =====
// Bit-serial signed divider: quotient = (num * 2^16) / den, truncated, clamped to 32 bits.
// Depends on kf2d_pkg.
module kf2d_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  kf2d_pkg::t_q16       i_num,
    input  logic signed [49:0]   i_den,
    output logic                 o_done,
    output kf2d_pkg::t_q16       o_quo
);
    import kf2d_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [5:0]          r_cnt;
    logic [QuoW-1:0]     r_quo;
    logic [49:0]         r_rem;
    logic [49:0]         r_dvs;
    logic                r_neg;

    logic [32:0]         w_num_abs;
    logic [49:0]         w_den_abs;
    logic [50:0]         w_rem_sh;
    logic [50:0]         w_rem_sub;
    logic                w_qbit;

    always_comb begin
        w_num_abs = i_num[31] ? -{i_num[31], i_num} : {i_num[31], i_num};
        w_den_abs = i_den[49] ? 50'(-i_den) : 50'(i_den);
        w_rem_sh  = {r_rem, r_quo[QuoW-1]};
        w_rem_sub = w_rem_sh - {1'b0, r_dvs};
        w_qbit    = (w_rem_sh >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(QuoW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= {w_num_abs[31:0], 16'd0};
            r_rem <= '0;
            r_dvs <= w_den_abs;
            r_neg <= i_num[31] ^ i_den[49];
        end else if (r_busy) begin
            r_rem <= w_qbit ? w_rem_sub[49:0] : w_rem_sh[49:0];
            r_quo <= {r_quo[QuoW-2:0], w_qbit};
        end
    end

    // apply sign and clamp
    always_comb begin
        if (r_neg) begin
            o_quo = (r_quo > QuoW'(33'h1_0000_0000 >> 1)) ? Q16_MIN : -r_quo[31:0];
        end else begin
            o_quo = (r_quo > QuoW'(32'h7FFF_FFFF)) ? Q16_MAX : r_quo[31:0];
        end
    end

    assign o_done = r_done;

endmodule

// ===== design/kalman_filter_2d_step.sv =====
// Top level of the 2-D Kalman predict/update step, signed Q16.16.
// Depends on kf2d_pkg, kf2d_div and assert_macros.svh.
//
// Channel   | Dir | Signals                          | Content
// s_axis    | in  | tvalid/tready/tdata[127:0]       | control_x, control_y, meas_x, meas_y
// m_axis    | out | tvalid/tready/tdata[255:0]/tuser | estimate, prior, covariance; singular
// cfg       | in  | i_cfg_we/i_cfg_idx/i_cfg_data    | walls and noise registers
//
// Sequence: each accepted beat runs on to the result load. Eleven multiply pairs
// run through one shared 33x33 multiplier, and four gain entries each wait on the
// bit-serial divider. A singular innovation covariance stops after the determinant.
// Reset is synchronous and restores registers, mean and covariance. A waiting
// result does not block the next input beat.
`include "assert_macros.svh"
module kalman_filter_2d_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [127:0]   s_axis_tdata,  // control_x, control_y, meas_x, meas_y
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [255:0]   m_axis_tdata,  // est_x, est_y, prior_x, prior_y,
                                          // var_xx, var_xy, var_yx, var_yy
    output logic           m_axis_tuser,  // singular
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [31:0]    i_cfg_data
);
    import kf2d_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PRE1 = 4'd1;
    localparam logic [3:0] S_PRE2 = 4'd2;
    localparam logic [3:0] S_M0   = 4'd3;
    localparam logic [3:0] S_M1   = 4'd4;
    localparam logic [3:0] S_AD   = 4'd5;
    localparam logic [3:0] S_FIN  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    localparam logic [3:0] J_DET  = 4'd0;
    localparam logic [3:0] J_LAST = 4'd10;

    // configuration
    t_q16 r_wall_x, r_wall_y, r_pn_xx, r_pn_xy, r_pn_yy, r_mn_xx, r_mn_xy, r_mn_yy;
    // filter state
    t_q16 r_mean_x, r_mean_y;
    t_q16 r_cov [4];
    // working registers
    logic [3:0]         r_state;
    logic [3:0]         r_j;
    t_q16               r_cx, r_cy, r_zx, r_zy;
    t_q16               r_px, r_py, r_vx, r_vy, r_ex, r_ey;
    t_q16               r_p  [4];
    t_q16               r_s  [4];
    t_q16               r_a  [4];
    t_q16               r_nc [4];
    logic signed [65:0] r_prod;
    t_wide              r_acc;
    logic signed [49:0] r_det;
    logic               r_sing;
    logic               r_mvalid;
    logic [255:0]       r_mdata;
    logic               r_muser;

    logic signed [32:0] w_opa, w_opb;
    logic signed [65:0] w_prod;
    t_wide              w_fl;
    logic               w_ph1;
    logic [3:0]         w_jm1, w_jm7;
    logic               w_div_start, w_div_done;
    t_q16               w_div_quo;
    logic               w_out_load;

    function automatic logic signed [32:0] f_x33(input t_q16 a);
        f_x33 = {a[31], a};
    endfunction

    // operand select for the shared multiplier
    always_comb begin
        w_ph1 = (r_state == S_M1);
        w_opa = '0;
        w_opb = '0;
        unique case (r_j)
            4'd0: begin
                w_opa = w_ph1 ? f_x33(r_s[1]) : f_x33(r_s[0]);
                w_opb = w_ph1 ? f_x33(r_s[2]) : f_x33(r_s[3]);
            end
            4'd1: begin
                w_opa = w_ph1 ? f_x33(r_p[1]) : f_x33(r_p[0]);
                w_opb = w_ph1 ? -f_x33(r_s[2]) : f_x33(r_s[3]);
            end
            4'd2: begin
                w_opa = w_ph1 ? f_x33(r_p[1]) : f_x33(r_p[0]);
                w_opb = w_ph1 ? f_x33(r_s[0]) : -f_x33(r_s[1]);
            end
            4'd3: begin
                w_opa = w_ph1 ? f_x33(r_p[3]) : f_x33(r_p[2]);
                w_opb = w_ph1 ? -f_x33(r_s[2]) : f_x33(r_s[3]);
            end
            4'd4: begin
                w_opa = w_ph1 ? f_x33(r_p[3]) : f_x33(r_p[2]);
                w_opb = w_ph1 ? f_x33(r_s[0]) : -f_x33(r_s[1]);
            end
            4'd5: begin
                w_opa = w_ph1 ? f_x33(r_a[1]) : f_x33(r_a[0]);
                w_opb = w_ph1 ? f_x33(r_vy) : f_x33(r_vx);
            end
            4'd6: begin
                w_opa = w_ph1 ? f_x33(r_a[3]) : f_x33(r_a[2]);
                w_opb = w_ph1 ? f_x33(r_vy) : f_x33(r_vx);
            end
            4'd7: begin
                w_opa = w_ph1 ? f_x33(r_a[1]) : f_x33(r_a[0]);
                w_opb = w_ph1 ? f_x33(r_p[2]) : f_x33(r_p[0]);
            end
            4'd8: begin
                w_opa = w_ph1 ? f_x33(r_a[1]) : f_x33(r_a[0]);
                w_opb = w_ph1 ? f_x33(r_p[3]) : f_x33(r_p[1]);
            end
            4'd9: begin
                w_opa = w_ph1 ? f_x33(r_a[3]) : f_x33(r_a[2]);
                w_opb = w_ph1 ? f_x33(r_p[2]) : f_x33(r_p[0]);
            end
            4'd10: begin
                w_opa = w_ph1 ? f_x33(r_a[3]) : f_x33(r_a[2]);
                w_opb = w_ph1 ? f_x33(r_p[3]) : f_x33(r_p[1]);
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
        w_prod = w_opa * w_opb;
        // arithmetic shift keeps floor rounding
        w_fl   = t_wide'($signed(r_prod[65:16]));
        w_jm1  = r_j - 4'd1;
        w_jm7  = r_j - 4'd7;
    end

    assign w_div_start   = (r_state == S_FIN) && (r_j != J_DET) && (r_j <= 4'd4);
    assign w_out_load    = (r_state == S_OUT) && (!r_mvalid || m_axis_tready);
    assign s_axis_tready = (r_state == S_IDLE);

    kf2d_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (f_sat32(r_acc)),
        .i_den   (r_det),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // configuration writes; the 3-bit index covers all eight registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wall_x <= RST_WALL_X;
            r_wall_y <= RST_WALL_Y;
            r_pn_xx  <= RST_PN_XX;
            r_pn_xy  <= '0;
            r_pn_yy  <= RST_PN_YY;
            r_mn_xx  <= RST_MN_XX;
            r_mn_xy  <= '0;
            r_mn_yy  <= RST_MN_YY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WALL_X: r_wall_x <= {1'b0, i_cfg_data[30:0]};
                REG_WALL_Y: r_wall_y <= {1'b0, i_cfg_data[30:0]};
                REG_PN_XX:  r_pn_xx  <= {1'b0, i_cfg_data[30:0]};
                REG_PN_XY:  r_pn_xy  <= i_cfg_data;
                REG_PN_YY:  r_pn_yy  <= {1'b0, i_cfg_data[30:0]};
                REG_MN_XX:  r_mn_xx  <= {1'b0, i_cfg_data[30:0]};
                REG_MN_XY:  r_mn_xy  <= i_cfg_data;
                REG_MN_YY:  r_mn_yy  <= {1'b0, i_cfg_data[30:0]};
                default:    r_wall_x <= r_wall_x;
            endcase
        end
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_j      <= J_DET;
            r_mvalid <= 1'b0;
            r_mean_x <= RST_MEAN_X;
            r_mean_y <= RST_MEAN_Y;
            r_cov[0] <= RST_COV0;
            r_cov[1] <= RST_COV1;
            r_cov[2] <= RST_COV2;
            r_cov[3] <= RST_COV3;
        end else begin
            if (w_out_load) begin
                r_mvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= S_PRE1;
                        r_j     <= J_DET;
                    end
                end
                S_PRE1: r_state <= S_PRE2;
                S_PRE2: r_state <= S_M0;
                S_M0:   r_state <= S_M1;
                S_M1:   r_state <= S_AD;
                S_AD:   r_state <= S_FIN;
                S_FIN: begin
                    priority if (r_j == J_DET) begin
                        // singular: skip the update, keep the prediction
                        r_state <= (r_acc == '0) ? S_OUT : S_M0;
                        r_j     <= 4'd1;
                    end else if (r_j <= 4'd4) begin
                        r_state <= S_DIV;
                    end else if (r_j == J_LAST) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_M0;
                        r_j     <= r_j + 4'd1;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_M0;
                        r_j     <= r_j + 4'd1;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state  <= S_IDLE;
                        r_mean_x <= r_ex;
                        r_mean_y <= r_ey;
                        r_cov    <= r_nc;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_cx   <= s_axis_tdata[31:0];
            r_cy   <= s_axis_tdata[63:32];
            r_zx   <= s_axis_tdata[95:64];
            r_zy   <= s_axis_tdata[127:96];
            r_sing <= 1'b0;
        end
        if (r_state == S_PRE1) begin
            r_px   <= f_sat32(f_ext(r_mean_x) + f_ext(r_cx));
            r_py   <= f_sat32(f_ext(r_mean_y) + f_ext(r_cy));
            r_p[0] <= f_sat32(f_ext(r_cov[0]) + f_ext(r_pn_xx));
            r_p[1] <= f_sat32(f_ext(r_cov[1]) + f_ext(r_pn_xy));
            r_p[2] <= f_sat32(f_ext(r_cov[2]) + f_ext(r_pn_xy));
            r_p[3] <= f_sat32(f_ext(r_cov[3]) + f_ext(r_pn_yy));
        end
        if (r_state == S_PRE2) begin
            r_s[0] <= f_sat32(f_ext(r_p[0]) + f_ext(r_mn_xx));
            r_s[1] <= f_sat32(f_ext(r_p[1]) + f_ext(r_mn_xy));
            r_s[2] <= f_sat32(f_ext(r_p[2]) + f_ext(r_mn_xy));
            r_s[3] <= f_sat32(f_ext(r_p[3]) + f_ext(r_mn_yy));
            r_vx   <= f_sat32(f_ext(r_zx)
                      - f_ext(f_sat32(f_ext(r_wall_x) - f_ext(r_px))));
            r_vy   <= f_sat32(f_ext(r_zy)
                      - f_ext(f_sat32(f_ext(r_wall_y) - f_ext(r_py))));
        end
        if (r_state == S_M0) begin
            r_prod <= w_prod;
        end
        if (r_state == S_M1) begin
            r_acc  <= w_fl;
            r_prod <= w_prod;
        end
        if (r_state == S_AD) begin
            r_acc <= (r_j == J_DET) ? r_acc - w_fl : r_acc + w_fl;
        end
        if (r_state == S_FIN) begin
            priority if (r_j == J_DET) begin
                r_det <= r_acc[49:0];
                if (r_acc == '0) begin
                    r_sing <= 1'b1;
                    r_ex   <= r_px;
                    r_ey   <= r_py;
                    r_nc   <= r_p;
                end
            end else if (r_j == 4'd5) begin
                r_ex <= f_sat32(f_ext(r_px) - r_acc);
            end else if (r_j == 4'd6) begin
                r_ey <= f_sat32(f_ext(r_py) - r_acc);
            end else if (r_j >= 4'd7) begin
                r_nc[w_jm7[1:0]] <= f_sat32(f_ext(r_p[w_jm7[1:0]]) - r_acc);
            end else begin
                r_det <= r_det;
            end
        end
        if (r_state == S_DIV && w_div_done) begin
            r_a[w_jm1[1:0]] <= w_div_quo;
        end
        if (w_out_load) begin
            r_mdata <= {r_nc[3], r_nc[2], r_nc[1], r_nc[0], r_py, r_px, r_ey, r_ex};
            r_muser <= r_sing;
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tuser  = r_muser;

    `ASSERT_CLK(a_sing_keeps_prior, i_clk, i_rst_n,
        (m_axis_tvalid && m_axis_tuser) |->
        (m_axis_tdata[31:0] == m_axis_tdata[95:64] &&
         m_axis_tdata[63:32] == m_axis_tdata[127:96]))
    `ASSERT_NEVER(a_step_range, i_clk, i_rst_n, r_j > J_LAST)
    `ASSERT_CLK(a_load_from_out, i_clk, i_rst_n,
        $rose(m_axis_tvalid) |-> $past(r_state == S_OUT))
    `ASSERT_NEVER(a_div_done_wait, i_clk, i_rst_n, w_div_done && r_state != S_DIV)

endmodule
